/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file; they sample on clk and hold off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MQS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("marquee assertion failed");

// Next-cycle implication.
`define MQS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("marquee assertion failed");

`endif

/* hw/rtl/mqs_pkg.sv */
// Package of the marquee scroll controller: constants, register codes and shared types.
`default_nettype none

package mqs_pkg;

	localparam int COORD_BITS     = 16;
	localparam int STEP_FRAC_BITS = 8;

	// Working width of the position arithmetic: box edge scaled by the step
	// fraction minus a 16 x 17 bit signed product, with headroom.
	localparam int VW = 34;

	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_PIXELS  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCROLL_MODE  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PAUSE_FRAMES = 2'd2;

	localparam logic [15:0] STEP_PIXELS_RESET  = 16'd256;
	localparam logic        SCROLL_MODE_RESET  = 1'b0;
	localparam logic [7:0]  PAUSE_FRAMES_RESET = 8'd20;

	localparam logic MODE_PINGPONG = 1'b0;
	localparam logic MODE_ONEWAY   = 1'b1;

	typedef struct packed {
		logic [15:0] step_pixels;
		logic        scroll_mode;
		logic [7:0]  pause_frames;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] box_left;
		logic signed [15:0] box_top;
		logic signed [15:0] box_right;
		logic signed [15:0] box_bottom;
		logic [14:0]        text_width;
		logic [14:0]        text_height;
		logic [15:0]        text_length;
		logic               center;
		logic               restart;
	} item_t;

	typedef struct packed {
		logic [15:0] scroll_offset;
		logic        reverse_dir;
		logic [7:0]  pause_count;
		logic        edge_latched;
		logic [15:0] last_length;
	} state_t;

	typedef struct packed {
		logic signed [15:0] text_x;
		logic signed [15:0] text_y;
		logic               scrolling;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/mqs_calc.sv */
// Per-frame placement logic: text position, scroll state update and result fields.
`default_nettype none

module mqs_calc (
	input  mqs_pkg::item_t   item,
	input  mqs_pkg::cfg_t    cfg,
	input  mqs_pkg::state_t  st,
	output mqs_pkg::state_t  st_next,
	output mqs_pkg::result_t res
);
	import mqs_pkg::*;

	localparam logic signed [VW-1:0] FRAC_MASK = VW'((64'sd1 <<< STEP_FRAC_BITS) - 64'sd1);
	localparam logic signed [VW-1:0] SAT_HI    = VW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [VW-1:0] SAT_LO    = -SAT_HI - VW'(1);

	// left * 2^F - offset * step, divided by 2^F toward zero
	function automatic logic signed [VW-1:0] place_x(logic signed [15:0] left,
			logic [15:0] off, logic [15:0] step);
		logic signed [32:0]   prod;
		logic signed [VW-1:0] v;
		logic signed [VW-1:0] q;
		prod = $signed(off) * $signed({1'b0, step});
		v = (VW'(left) <<< STEP_FRAC_BITS) - VW'(prod);
		q = v >>> STEP_FRAC_BITS;
		if (v[VW-1] && ((v & FRAC_MASK) != '0)) begin
			q = q + VW'(1);
		end
		return q;
	endfunction

	function automatic logic signed [VW-1:0] half_tz(logic signed [VW-1:0] a);
		logic signed [VW-1:0] t;
		t = a + VW'(a[VW-1]);
		return t >>> 1;
	endfunction

	function automatic logic signed [15:0] sat16(logic signed [VW-1:0] a);
		logic signed [VW-1:0] t;
		t = a;
		if (a > SAT_HI) begin
			t = SAT_HI;
		end else if (a < SAT_LO) begin
			t = SAT_LO;
		end
		return t[15:0];
	endfunction

	logic signed [VW-1:0] left, top, right, bottom, tw, th, bw, bh;
	logic signed [VW-1:0] x_a, x_b, x, y, il, ir, it, ib;
	logic                 scrolling, do_reset, at_edge, mode1;
	logic [15:0]          off0, off1, off2;
	logic [7:0]           pc0, pc1, pc2;
	logic                 rev0, rev1, el0, el1;

	always_comb begin
		left   = VW'(item.box_left);
		top    = VW'(item.box_top);
		right  = VW'(item.box_right);
		bottom = VW'(item.box_bottom);
		tw     = VW'(item.text_width);
		th     = VW'(item.text_height);
		bw     = right - left;
		bh     = bottom - top;
		scrolling = tw > bw;
		mode1     = (cfg.scroll_mode == MODE_ONEWAY);

		// a new text or an explicit restart sends the scroll home
		do_reset = item.restart || (item.text_length != st.last_length);
		off0 = do_reset ? 16'd0 : st.scroll_offset;
		pc0  = do_reset ? cfg.pause_frames : st.pause_count;
		rev0 = (do_reset && !mode1) ? 1'b0 : st.reverse_dir;
		el0  = (do_reset && !mode1) ? 1'b0 : st.edge_latched;

		y   = top + half_tz(bh - th);
		x_a = place_x(item.box_left, off0, cfg.step_pixels);
		x_b = place_x(item.box_left, off0 - 16'd1, cfg.step_pixels);
		x   = item.center ? left + half_tz(bw - tw) : left;

		at_edge = ((x_a + tw) < right) || (x_a > left);
		off1 = off0;
		pc1  = pc0;
		rev1 = rev0;
		el1  = el0;
		if (scrolling) begin
			x = x_a;
			if (!mode1) begin
				if (at_edge) begin
					if (!el0) begin
						rev1 = ~rev0;
						pc1  = cfg.pause_frames;
					end
					el1 = 1'b1;
				end else begin
					el1 = 1'b0;
				end
			end else if (at_edge) begin
				// back off one unit and hold
				off1 = off0 - 16'd1;
				x    = x_b;
				pc1  = cfg.pause_frames;
			end
		end

		off2 = off1;
		pc2  = pc1;
		if (pc1 == 8'd0) begin
			off2 = (!mode1 && rev1) ? off1 - 16'd1 : off1 + 16'd1;
		end else begin
			pc2 = pc1 - 8'd1;
			if (mode1 && (pc2 == (cfg.pause_frames >> 1))) begin
				off2 = 16'd0;
			end
		end

		il = (x > left) ? x : left;
		ir = ((x + tw) < right) ? (x + tw) : right;
		it = (y > top) ? y : top;
		ib = ((y + th) < bottom) ? (y + th) : bottom;
		if ((ir <= il) || (ib <= it)) begin
			off2 = 16'd0;
			pc2  = cfg.pause_frames;
		end

		st_next.scroll_offset = off2;
		st_next.reverse_dir   = rev1;
		st_next.pause_count   = pc2;
		st_next.edge_latched  = el1;
		st_next.last_length   = item.text_length;

		res.text_x    = sat16(x);
		res.text_y    = sat16(y);
		res.scrolling = scrolling;
	end

endmodule

`default_nettype wire

/* hw/rtl/marquee_scroll_controller.sv */
// Top level of the marquee scroll controller: handshakes, registers and scroll state.
// Usage:
//   Feed one item per display frame on the input channel (in_valid/in_ready):
//   box rectangle, text size and length, center and restart flags.
//   Each item yields exactly one result on the output channel
//   (out_valid/out_ready): text_x, text_y and the scrolling flag.
//   Flow: an item accepted at a clock edge is registered in the input register,
//   worked on combinationally, and its result is then registered at the output.
//   Throughput: one item per cycle while out_ready is high; the placement multiply,
//   compares and counter updates all sit between the input and output registers.
//   When the receiver stalls, the result holds in the output register and one
//   more item waits in the input register; in_ready drops only when both are full.
//   Configuration: cfg_we writes cfg_data into register cfg_index at once
//   (0 step_pixels, 1 scroll_mode, 2 pause_frames); write only while idle.
//   Reset: registers return to step 1.0 pixel, ping-pong mode, 20-frame pause;
//   scroll state clears; both channels empty.
`default_nettype none

module marquee_scroll_controller (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mqs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [15:0]                         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [15:0]                  box_left,
	input  wire logic signed [15:0]                  box_top,
	input  wire logic signed [15:0]                  box_right,
	input  wire logic signed [15:0]                  box_bottom,
	input  wire logic [14:0]                         text_width,
	input  wire logic [14:0]                         text_height,
	input  wire logic [15:0]                         text_length,
	input  wire logic                                center,
	input  wire logic                                restart,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [15:0]                       text_x,
	output logic signed [15:0]                       text_y,
	output logic                                     scrolling
);
	import mqs_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_next;
	result_t res_next;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	// move the held item into the result register when that register frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_pixels  <= STEP_PIXELS_RESET;
			cfg_q.scroll_mode  <= SCROLL_MODE_RESET;
			cfg_q.pause_frames <= PAUSE_FRAMES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEP_PIXELS:  cfg_q.step_pixels  <= cfg_data;
				CFG_SCROLL_MODE:  cfg_q.scroll_mode  <= cfg_data[0];
				CFG_PAUSE_FRAMES: cfg_q.pause_frames <= cfg_data[7:0];
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	// input register: payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.box_left    <= box_left;
			item_s1.box_top     <= box_top;
			item_s1.box_right   <= box_right;
			item_s1.box_bottom  <= box_bottom;
			item_s1.text_width  <= text_width;
			item_s1.text_height <= text_height;
			item_s1.text_length <= text_length;
			item_s1.center      <= center;
			item_s1.restart     <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	mqs_calc u_calc (
		.item    (item_s1),
		.cfg     (cfg_q),
		.st      (state_q),
		.st_next (state_next),
		.res     (res_next)
	);

	// scroll state advances once per item, as its result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign text_x    = res_q.text_x;
	assign text_y    = res_q.text_y;
	assign scrolling = res_q.scrolling;

`include "assert_macros.svh"

	// a held item always lands in the result register on advance
	`MQS_ASSERT_NXT(a_advance_fills_out, advance, out_valid_q)
	// input back-pressure only when both registers are full and the receiver stalls
	`MQS_ASSERT_IMP(a_ready_only_stalled, !in_ready, valid_s1 && out_valid_q && !out_ready)
	// scroll state moves only with an item
	`MQS_ASSERT_NXT(a_state_holds, !advance, $stable(state_q))

endmodule

`default_nettype wire

/* tb/sv/marquee_scroll_controller_test.sv */
// Self-checking bench for the marquee scroll controller: directed frames, then random scenes.
`timescale 1ns / 100ps

module marquee_scroll_controller_test;
	import mqs_pkg::*;

	localparam int HOLD_CYCLES     = 200;
	localparam int QUIET_LIMIT     = 4000;
	localparam int FRAMES_PER_PASS = 210;
	localparam int PRINT_CAP       = 100;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum bit {ROW_FRAME, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  reg_index;
		logic [15:0] reg_value;
		item_t       frame;
		bit          typed;
		result_t     want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	item_t frame_in;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] text_x;
	logic signed [15:0] text_y;
	logic scrolling;

	// Predictor copy of the scroll state and the register file.
	state_t track;
	cfg_t regs;

	result_t placements_due [$];
	stim_row_t directed_rows [$];
	idle_mode_t idle_mode = IDLE_NONE;
	bit hold_pending = 1'b0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	marquee_scroll_controller dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.box_left    (frame_in.box_left),
		.box_top     (frame_in.box_top),
		.box_right   (frame_in.box_right),
		.box_bottom  (frame_in.box_bottom),
		.text_width  (frame_in.text_width),
		.text_height (frame_in.text_height),
		.text_length (frame_in.text_length),
		.center      (frame_in.center),
		.restart     (frame_in.restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.text_x      (text_x),
		.text_y      (text_y),
		.scrolling   (scrolling)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Percentage of cycles in which one side sits out, per idling phase.
	function automatic int idle_pct(input bit receiver);
		case (idle_mode)
			IDLE_SEND: return receiver ? 0 : 72;
			IDLE_RECV: return receiver ? 72 : 0;
			IDLE_BOTH: return 37;
			default:   return 0;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Placement predictor
	// ---------------------------------------------------------------

	function automatic void go_home();
		track.scroll_offset = '0;
		track.pause_count   = regs.pause_frames;
	endfunction

	// Left edge shifted by offset * step, fixed point, truncated toward zero.
	function automatic longint scrolled_x(input longint lft);
		longint scale;
		scale = longint'(1) << STEP_FRAC_BITS;
		return (lft * scale - longint'($signed(track.scroll_offset))
			* longint'(regs.step_pixels)) / scale;
	endfunction

	function automatic logic signed [15:0] clamp_coord(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (COORD_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			v = hi;
		else if (v < lo)
			v = lo;
		return v[15:0];
	endfunction

	// Work out where the text of one frame lands and advance the scroll state.
	function automatic result_t place_text(input item_t f);
		longint lft, top, rgt, bot, tw, th, bw, bh, x, y;
		longint ovl_l, ovl_r, ovl_t, ovl_b;
		bit wide;
		bit rehome;
		result_t r;
		lft = longint'(f.box_left);
		top = longint'(f.box_top);
		rgt = longint'(f.box_right);
		bot = longint'(f.box_bottom);
		tw  = longint'(f.text_width);
		th  = longint'(f.text_height);
		bw  = rgt - lft;
		bh  = bot - top;
		wide = tw > bw;

		// A new text length counts as a restart.
		rehome = f.restart;
		if (f.text_length != track.last_length) begin
			rehome = 1'b1;
			track.last_length = f.text_length;
		end
		if (rehome) begin
			go_home();
			if (regs.scroll_mode == MODE_PINGPONG) begin
				track.reverse_dir  = 1'b0;
				track.edge_latched = 1'b0;
			end
		end

		y = top + (bh - th) / 2;
		x = f.center ? lft + (bw - tw) / 2 : lft;

		if (wide) begin
			x = scrolled_x(lft);
			if (x + tw < rgt || x > lft) begin
				if (regs.scroll_mode == MODE_PINGPONG) begin
					// Flip once per edge visit, then hold the latch.
					if (!track.edge_latched) begin
						track.reverse_dir = ~track.reverse_dir;
						track.pause_count = regs.pause_frames;
					end
					track.edge_latched = 1'b1;
				end else begin
					// Back off one unit and wait at the edge.
					track.scroll_offset -= 16'd1;
					x = scrolled_x(lft);
					track.pause_count = regs.pause_frames;
				end
			end else if (regs.scroll_mode == MODE_PINGPONG) begin
				track.edge_latched = 1'b0;
			end
		end

		if (track.pause_count == 8'd0) begin
			if (regs.scroll_mode == MODE_PINGPONG && track.reverse_dir)
				track.scroll_offset -= 16'd1;
			else
				track.scroll_offset += 16'd1;
		end else begin
			track.pause_count -= 8'd1;
			// One-way mode snaps home halfway through the pause.
			if (regs.scroll_mode == MODE_ONEWAY
					&& track.pause_count == (regs.pause_frames >> 1))
				track.scroll_offset = '0;
		end

		// Drop the scroll when text and box share no area.
		ovl_l = x > lft ? x : lft;
		ovl_r = (x + tw) < rgt ? (x + tw) : rgt;
		ovl_t = y > top ? y : top;
		ovl_b = (y + th) < bot ? (y + th) : bot;
		if (ovl_r <= ovl_l || ovl_b <= ovl_t)
			go_home();

		r.text_x    = clamp_coord(x);
		r.text_y    = clamp_coord(y);
		r.scrolling = wide;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic void add_frame(input int l, t, r, b, tw, th, len,
			input bit c, rs, chk, input int wx, wy, input bit ws);
		stim_row_t row;
		row.kind               = ROW_FRAME;
		row.reg_index          = '0;
		row.reg_value          = '0;
		row.frame.box_left     = l[15:0];
		row.frame.box_top      = t[15:0];
		row.frame.box_right    = r[15:0];
		row.frame.box_bottom   = b[15:0];
		row.frame.text_width   = tw[14:0];
		row.frame.text_height  = th[14:0];
		row.frame.text_length  = len[15:0];
		row.frame.center       = c;
		row.frame.restart      = rs;
		row.typed              = chk;
		row.want.text_x        = wx[15:0];
		row.want.text_y        = wy[15:0];
		row.want.scrolling     = ws;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_reg(input logic [1:0] idx, input logic [15:0] val);
		stim_row_t row;
		row.kind      = ROW_REG;
		row.reg_index = idx;
		row.reg_value = val;
		row.frame     = '0;
		row.typed     = 1'b0;
		row.want      = '0;
		directed_rows.push_back(row);
	endfunction

	// Mostly text a little wider than a modest box, so the edges are reached.
	function automatic item_t pick_scene();
		item_t s;
		int bw;
		int lft;
		int top;
		if ($urandom_range(0, 7) == 0) begin
			bw  = int'($urandom_range(0, 30000));
			lft = -32768 + int'($urandom_range(0, 2000));
		end else begin
			bw = int'($urandom_range(0, 300));
			if ($urandom_range(0, 3) == 0)
				lft = -32768 + int'($urandom_range(0, 600));
			else
				lft = int'($urandom_range(0, 4000)) - 2000;
		end
		top = int'($urandom_range(0, 400)) - 200;
		s.box_left    = lft[15:0];
		s.box_right   = 16'(lft + bw);
		s.box_top     = top[15:0];
		s.box_bottom  = 16'(top + int'($urandom_range(0, 60)));
		s.text_height = 15'($urandom_range(0, 70));
		if ($urandom_range(0, 3) != 0)
			s.text_width = 15'(bw + int'($urandom_range(1, 64)));
		else
			s.text_width = 15'($urandom_range(0, bw));
		s.text_length = 16'($urandom);
		s.center      = 1'($urandom);
		s.restart     = 1'b0;
		return s;
	endfunction

	// Offer one frame, hold it until taken, then log its placement.
	task automatic drive_item(input item_t frame, input bit typed, input result_t want);
		result_t due;
		while (chance(idle_pct(1'b0))) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_in <= frame;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		due = place_text(frame);
		placements_due.push_back(typed ? want : due);
	endtask

	// Write a register once the pipeline has drained.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		in_valid <= 1'b0;
		while (placements_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_STEP_PIXELS:  regs.step_pixels  = val;
			CFG_SCROLL_MODE:  regs.scroll_mode  = val[0];
			CFG_PAUSE_FRAMES: regs.pause_frames = val[7:0];
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t ps: %s: got %0d, want %0d", $realtime * 1000, what, got, want);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------

	// Drive ready; on request, hold off long enough to back up the input.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= !chance(idle_pct(1'b1));
		end
	end

	// Sample between edges, where every signal is settled.
	always @(negedge clk) begin : result_monitor
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (placements_due.size() == 0) begin
				flag_mismatch("result with nothing due, text_x", text_x, 0);
			end else begin
				want = placements_due.pop_front();
				if (text_x !== want.text_x)
					flag_mismatch("text_x", text_x, want.text_x);
				if (text_y !== want.text_y)
					flag_mismatch("text_y", text_y, want.text_y);
				if (scrolling !== want.scrolling)
					flag_mismatch("scrolling", scrolling, want.scrolling);
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// Watchdog: give up when nothing moves on either channel for too long.
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin
		item_t scene;
		item_t frame;
		logic [127:0] noise;
		int run;
		int roll;
		int sent;
		logic [15:0] phase_step [8];
		logic        phase_mode [8];
		logic [7:0]  phase_pause [8];

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		frame_in  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;

		track = '0;
		regs.step_pixels  = STEP_PIXELS_RESET;
		regs.scroll_mode  = SCROLL_MODE_RESET;
		regs.pause_frames = PAUSE_FRAMES_RESET;

		// Reset values: 1.0 px step, ping-pong, 20-frame pause.
		add_frame(0, 0, 100, 20, 40, 10, 0, 0, 0, 1, 0, 5, 0);
		add_frame(0, 0, 100, 20, 40, 10, 0, 1, 0, 1, 30, 5, 0);
		add_frame(-32768, -32768, 32767, 32767, 32767, 32767, 0, 1, 0,
			1, -16384, -16384, 0);
		// Empty box: no common area, scroll goes home.
		add_frame(10, 0, 10, 0, 0, 0, 0, 0, 0, 1, 10, 0, 0);
		// Inverted box with new length, zero-height text, restart at max length.
		add_frame(32767, 32767, -32768, -32768, 32767, 0, 65535, 1, 0, 0, 0, 0, 0);
		add_frame(0, 0, 100, 20, 40, 0, 65535, 0, 0, 0, 0, 0, 0);
		add_frame(0, 0, 100, 20, 40, 10, 65535, 0, 1, 0, 0, 0, 0);

		// Ping-pong run: 32 px per unit, short pause, both edges visited.
		add_reg(CFG_STEP_PIXELS, 16'h2000);
		add_reg(CFG_PAUSE_FRAMES, 16'd2);
		for (int i = 0; i < 10; i++)
			add_frame(0, 0, 100, 20, 150, 10, 7, 0, 0, 0, 0, 0, 0);
		add_frame(0, 0, 100, 20, 150, 10, 7, 0, 1, 0, 0, 0, 0);

		// One-way run: back off at the edge, then snap home mid-pause.
		add_reg(CFG_SCROLL_MODE, 16'(MODE_ONEWAY));
		for (int i = 0; i < 7; i++)
			add_frame(0, 0, 100, 20, 150, 10, 9, 0, 0, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG)
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
			else
				drive_item(directed_rows[i].frame, directed_rows[i].typed,
					directed_rows[i].want);
		end

		// Register settings per random pass; extremes first, two passes random.
		phase_step  = '{16'd256, 16'd0, 16'hFFFF, 16'd128, 16'd0, 16'd0, 16'd768, 16'd256};
		phase_mode  = '{MODE_PINGPONG, MODE_ONEWAY, MODE_PINGPONG, MODE_ONEWAY,
			MODE_PINGPONG, MODE_ONEWAY, MODE_PINGPONG, MODE_ONEWAY};
		phase_pause = '{8'd20, 8'd0, 8'd255, 8'd7, 8'd0, 8'd0, 8'd0, 8'd255};

		for (int p = 0; p < 8; p++) begin
			if (p == 4 || p == 5) begin
				phase_step[p]  = 16'($urandom);
				phase_pause[p] = 8'($urandom_range(0, 15));
			end
			write_reg(CFG_STEP_PIXELS, phase_step[p]);
			write_reg(CFG_SCROLL_MODE, 16'(phase_mode[p]));
			write_reg(CFG_PAUSE_FRAMES, 16'(phase_pause[p]));
			idle_mode = idle_mode_t'(p % 4);
			// Back up the block once while frames keep coming at full rate.
			if (p == 0)
				hold_pending = 1'b1;

			sent = 0;
			while (sent < FRAMES_PER_PASS) begin
				scene = pick_scene();
				run = int'($urandom_range(4, 40));
				if ($urandom_range(0, 1) == 1)
					run += int'(regs.pause_frames);
				for (int k = 0; k < run && sent < FRAMES_PER_PASS; k++) begin
					roll = int'($urandom_range(0, 99));
					if (roll < 8) begin
						// Noise: every field fully random.
						noise = {$urandom, $urandom, $urandom, $urandom};
						frame = noise[$bits(item_t)-1:0];
					end else begin
						frame = scene;
						if (roll < 11) begin
							frame.restart = 1'b1;
						end else if (roll < 13) begin
							scene.text_length = 16'($urandom);
							frame.text_length = scene.text_length;
						end
					end
					drive_item(frame, 1'b0, '0);
					sent++;
				end
			end
		end

		in_valid <= 1'b0;
		idle_mode = IDLE_NONE;
		while (placements_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mqs_pkg.sv
hw/rtl/mqs_calc.sv
hw/rtl/marquee_scroll_controller.sv
tb/sv/marquee_scroll_controller_test.sv
